// ----- design/clpm_pkg.sv -----
package clpm_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;
  localparam int ADDR_BITS = 16 * 8;
  localparam int V4_PREFIX_OFFSET = 96;
  localparam logic [31:0] V4_MAPPED_MARK = 32'h0000_ffff;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix;
    logic [31:0] row;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        insert;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  key_prefix;
  } match_req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] masked_high;
    logic [63:0] masked_low;
  } match_rsp_t;

endpackage

// ----- design/clpm_ram.sv -----
module clpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/clpm_match.sv -----
module clpm_match (
  input  clpm_pkg::match_req_t req,
  input  clpm_pkg::entry_t     entry,
  output clpm_pkg::match_rsp_t rsp
);
  import clpm_pkg::*;

  logic [7:0]           mask_prefix;
  logic [ADDR_BITS-1:0] mask;
  logic [ADDR_BITS-1:0] masked;

  // insert masks by its own prefix, lookup by the stored entry's prefix
  assign mask_prefix = req.insert ? req.key_prefix : entry.prefix;
  assign mask = ~({ADDR_BITS{1'b1}} >> mask_prefix);
  assign masked = {req.key_high, req.key_low} & mask;

  always_comb begin
    rsp.masked_high = masked[ADDR_BITS-1:64];
    rsp.masked_low = masked[63:0];
    rsp.hit = (masked == {entry.addr_high, entry.addr_low}) &&
              (!req.insert || (entry.prefix == req.key_prefix));
  end

endmodule

// ----- design/cidr_longest_prefix_match_table.sv -----
// longest prefix match table for ipv6 networks, ipv4 mapped as ::ffff:a.b.c.d
// request channel (req_valid/req_ready) carries command, address, is_v4,
// prefix_len and row_number; response channel (rsp_valid/rsp_ready) carries
// status, match_row and match_prefix, one response per request.
// clear empties the table; insert adds a masked network unless it is a
// duplicate or the table is full; lookup returns the longest matching prefix.
// insert and lookup read the stored entries one per cycle from a single
// table ram through one shared masked comparator; a request scans every stored
// entry before its response, an insert that writes adds a write step, and clear
// and the unused command go straight to the response.
// req_ready is high only while no request is in work, so the next request can be
// taken in the same cycle that the response goes valid; the response sits in an
// output register, so the next request is taken while it waits.
// a stalled receiver holds the response and, once the next request is done,
// holds the sequencer until the register frees up.
// reset empties the table at once (entry count to zero); no clearing pass.
module cidr_longest_prefix_match_table #(
  parameter int TABLE_ENTRIES = clpm_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  command,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic        is_v4,
  input  logic [7:0]  prefix_len,
  input  logic [31:0] row_number,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [31:0] match_row,
  output logic [7:0]  match_prefix
);
  import clpm_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue_idx;
  logic             pend;
  logic             insert;
  logic [63:0]      key_high;
  logic [63:0]      key_low;
  logic [7:0]       key_prefix;
  logic [31:0]      key_row;
  logic             found;
  logic             dup;
  logic [7:0]       best_prefix;
  logic [31:0]      best_row;
  logic [1:0]       res_status;

  logic       req_xfer;
  logic       rsp_load;
  logic       rd_en;
  logic       ram_we;
  logic [8:0] prefix_sum;
  logic [7:0] prefix_clamped;
  entry_t     ram_q;
  entry_t     wr_entry;
  match_req_t mreq;
  match_rsp_t mrsp;

  assign req_ready = (state == S_IDLE);
  assign req_xfer = req_valid && req_ready;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign rd_en = (state == S_SCAN) && (issue_idx < count);
  assign ram_we = (state == S_WRITE);

  assign prefix_sum = {1'b0, prefix_len} + (is_v4 ? 9'(V4_PREFIX_OFFSET) : 9'd0);
  assign prefix_clamped = (prefix_sum > 9'(ADDR_BITS)) ? 8'(ADDR_BITS) : prefix_sum[7:0];

  always_comb begin
    mreq.insert = insert;
    mreq.key_high = key_high;
    mreq.key_low = key_low;
    mreq.key_prefix = key_prefix;
    wr_entry.addr_high = mrsp.masked_high;
    wr_entry.addr_low = mrsp.masked_low;
    wr_entry.prefix = key_prefix;
    wr_entry.row = key_row;
  end

  clpm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(wr_entry),
    .re   (rd_en),
    .raddr(issue_idx[IDX_W-1:0]),
    .rdata(ram_q)
  );

  clpm_match u_match (
    .req  (mreq),
    .entry(ram_q),
    .rsp  (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      pend <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            insert <= (command == CMD_INSERT);
            if (is_v4) begin
              key_high <= '0;
              key_low <= {V4_MAPPED_MARK, addr_low[31:0]};
            end else begin
              key_high <= addr_high;
              key_low <= addr_low;
            end
            key_prefix <= prefix_clamped;
            key_row <= row_number;
            issue_idx <= '0;
            found <= 1'b0;
            dup <= 1'b0;
            best_prefix <= '0;
            best_row <= '0;
            res_status <= ST_OK;
            case (command)
              CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              CMD_INSERT, CMD_LOOKUP: state <= S_SCAN;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          // compare runs in the cycle after the ram read
          if (pend && mrsp.hit) begin
            if (insert) begin
              dup <= 1'b1;
            end else if (!found || (ram_q.prefix > best_prefix)) begin
              found <= 1'b1;
              best_prefix <= ram_q.prefix;
              best_row <= ram_q.row;
            end
          end
          if (!rd_en && !pend) begin
            if (insert) begin
              if (dup) begin
                res_status <= ST_DUP;
                state <= S_DONE;
              end else if (count >= FULL_COUNT) begin
                res_status <= ST_FULL;
                state <= S_DONE;
              end else begin
                state <= S_WRITE;
              end
            end else begin
              res_status <= found ? ST_OK : ST_NOT_FOUND;
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status <= res_status;
      match_row <= best_row;
      match_prefix <= best_prefix;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above table size");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (count < FULL_COUNT) && insert && !dup)
    else $error("table write without room or on duplicate");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside done state");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> pend)
    else $error("ram read not followed by compare");

endmodule

// ----- sim/cidr_longest_prefix_match_table_tb.sv -----
`timescale 1ns / 1ps

module cidr_longest_prefix_match_table_tb;
  import clpm_pkg::*;

  localparam int TABLE_N = TABLE_ENTRIES_DEFAULT;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 1950;
  localparam int STUCK_LIMIT = 4000;
  localparam int RSP_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v4;
    logic [7:0]  plen;
    logic [31:0] row;
  } lpm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] row;
    logic [7:0]  plen;
  } lpm_rsp_t;

  typedef struct packed {
    lpm_req_t req;
    bit       known;
    lpm_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  logic [1:0] command;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic is_v4;
  logic [7:0] prefix_len;
  logic [31:0] row_number;
  logic rsp_valid;
  logic rsp_ready;
  logic [1:0] status;
  logic [31:0] match_row;
  logic [7:0] match_prefix;

  // predictor copy of the table
  logic [127:0] net_key [TABLE_N];
  logic [7:0] net_len [TABLE_N];
  logic [31:0] net_row [TABLE_N];
  int unsigned net_count;

  lpm_rsp_t pending_results[$];
  lpm_rsp_t rsp_want;
  logic [127:0] addr_pool [4];
  int errors;
  int stuck_cycles;
  int stall_left;
  bit quiet;
  bit stall_rsp_req;

  cidr_longest_prefix_match_table uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .command(command),
    .addr_high(addr_high),
    .addr_low(addr_low),
    .is_v4(is_v4),
    .prefix_len(prefix_len),
    .row_number(row_number),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .status(status),
    .match_row(match_row),
    .match_prefix(match_prefix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] prefix_mask(input int unsigned p);
    if (p == 0) return '0;
    return ~128'd0 << (ADDR_BITS - p);
  endfunction

  // applies one request to the predictor table and returns its response
  function automatic lpm_rsp_t lpm_apply(input lpm_req_t rq);
    lpm_rsp_t r;
    logic [127:0] key;
    int unsigned p;
    bit hit;
    r = '{status: ST_OK, row: '0, plen: '0};
    key = rq.v4 ? {64'd0, V4_MAPPED_MARK, rq.lo[31:0]} : {rq.hi, rq.lo};
    case (rq.cmd)
      CMD_CLEAR: net_count = 0;
      CMD_INSERT: begin
        p = int'(rq.plen) + (rq.v4 ? V4_PREFIX_OFFSET : 0);
        if (p > ADDR_BITS) p = ADDR_BITS;
        key &= prefix_mask(p);
        for (int i = 0; i < net_count; i++) begin
          if (net_key[i] == key && net_len[i] == p) begin
            r.status = ST_DUP;
            return r;
          end
        end
        if (net_count >= TABLE_N) begin
          r.status = ST_FULL;
        end else begin
          net_key[net_count] = key;
          net_len[net_count] = 8'(p);
          net_row[net_count] = rq.row;
          net_count++;
        end
      end
      CMD_LOOKUP: begin
        hit = 0;
        for (int i = 0; i < net_count; i++) begin
          if ((key & prefix_mask(net_len[i])) == net_key[i] &&
              (!hit || net_len[i] > r.plen)) begin
            hit = 1;
            r.plen = net_len[i];
            r.row = net_row[i];
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_len(input bit v4);
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(v4 ? 33 : 129, 255));
    return 8'($urandom_range(0, v4 ? 32 : 128));
  endfunction

  // fresh: fully random address; else an address near one of the pool bases
  function automatic lpm_req_t pool_req(input logic [1:0] cmd, input bit fresh);
    lpm_req_t rq;
    logic [127:0] key, m;
    int unsigned b;
    b = $urandom_range(0, 3);
    m = prefix_mask($urandom_range(0, ADDR_BITS));
    key = {$urandom, $urandom, $urandom, $urandom};
    if (!fresh) key = (addr_pool[b] & m) | (key & ~m);
    rq.cmd = cmd;
    rq.row = $urandom;
    rq.v4 = (b == 0 && $urandom_range(0, 2) != 0) || $urandom_range(0, 9) == 0;
    if (rq.v4) begin
      rq.hi = {$urandom, $urandom};
      rq.lo = {$urandom, key[31:0]};
    end else begin
      rq.hi = key[127:64];
      rq.lo = key[63:0];
    end
    rq.plen = (cmd == CMD_INSERT) ? pick_len(rq.v4) : 8'($urandom);
    return rq;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] cmd, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic v4,
                                      input logic [7:0] plen, input logic [31:0] row,
                                      input bit known, input logic [1:0] st,
                                      input logic [31:0] mrow, input logic [7:0] mpre);
    dir_row_t d;
    d.req = '{cmd: cmd, hi: hi, lo: lo, v4: v4, plen: plen, row: row};
    d.known = known;
    d.rsp = '{status: st, row: mrow, plen: mpre};
    return d;
  endfunction

  task automatic send_req(input lpm_req_t rq, input bit known, input lpm_rsp_t typed);
    lpm_rsp_t pred;
    while (!quiet && $urandom_range(0, 99) < 28) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= rq.cmd;
    addr_high <= rq.hi;
    addr_low <= rq.lo;
    is_v4 <= rq.v4;
    prefix_len <= rq.plen;
    row_number <= rq.row;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = lpm_apply(rq);
    pending_results = {pending_results, (known ? typed : pred)};
  endtask

  // response side: random stalls plus one long hold-off on request
  initial begin
    rsp_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_rsp_req) begin
        stall_rsp_req = 0;
        stall_left = RSP_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= quiet || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response with none expected: status %0d row %0h prefix %0d",
                 $time, status, match_row, match_prefix);
        errors++;
      end else begin
        rsp_want = pending_results.pop_front();
        if (status !== rsp_want.status) begin
          $display("%0t: status expected %0d got %0d", $time, rsp_want.status, status);
          errors++;
        end
        if (match_row !== rsp_want.row) begin
          $display("%0t: match_row expected %0h got %0h", $time, rsp_want.row, match_row);
          errors++;
        end
        if (match_prefix !== rsp_want.plen) begin
          $display("%0t: match_prefix expected %0d got %0d", $time, rsp_want.plen,
                   match_prefix);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tab[$];
    lpm_req_t rq;
    lpm_req_t replay[$];
    int n_rand;
    int ep_len;
    int r;
    bit big;
    bit pressed;
    rst = 1'b1;
    req_valid = 1'b0;
    command = CMD_CLEAR;
    addr_high = '0;
    addr_low = '0;
    is_v4 = 1'b0;
    prefix_len = '0;
    row_number = '0;
    errors = 0;
    stuck_cycles = 0;
    net_count = 0;
    quiet = 0;
    stall_rsp_req = 0;
    pressed = 0;

    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'd0, 64'd1, 0, 8'd0, 32'd0,
                               1, ST_NOT_FOUND, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, '1, '1, 0, 8'd0, 32'd7,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'd0, 64'd0, 0, 8'd0, 32'd0,
                               1, ST_OK, 32'd7, 8'd0)};
    // prefix over 128 clamps, so the /128 insert after it is a duplicate
    dir_tab = {dir_tab, mk_row(CMD_INSERT, '1, '1, 0, 8'd255, '1,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, '1, '1, 0, 8'd128, 32'd1,
                               1, ST_DUP, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, '1, '1, 0, 8'd0, 32'd0,
                               1, ST_OK, '1, 8'd128)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, '1, 64'hffffffff_0a000000, 1, 8'd8, 32'd100,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'h1234, 64'h12345678_0a010203, 1, 8'd0, 32'd0,
                               1, ST_OK, 32'd100, 8'd104)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'd0, 64'h0a010203, 1, 8'd255, 32'd5,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, '1, 64'h0a010203, 1, 8'd0, 32'd0,
                               1, ST_OK, 32'd5, 8'd128)};
    // same host written in mapped ipv6 form
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'd0, 64'h0000ffff_0a010203, 0, 8'd0, 32'd0,
                               1, ST_OK, 32'd5, 8'd128)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'd0, '1, 1, 8'd0, 32'd9,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'd0, 64'hc0a80001, 1, 8'd0, 32'd0,
                               1, ST_OK, 32'd9, 8'd96)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'd0, 64'h0000ffff_12345678, 0, 8'd96, 32'd3,
                               1, ST_DUP, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'h8000_0000_0000_0000, 64'd0, 0, 8'd1, 32'h55,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'hc000_0000_0000_0000, 64'd0, 0, 8'd0, 32'd0,
                               1, ST_OK, 32'h55, 8'd1)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'h0123456789abcdef, 64'hfedcba9876543210, 0,
                               8'd64, 32'haaaa5555, 0, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'h0123456789abcdef, 64'd0, 0, 8'd0, 32'd0,
                               0, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_UNUSED, '1, '1, 1, '1, '1,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, '1, '1, 0, 8'd0, 32'd0,
                               1, ST_OK, '1, 8'd128)};
    dir_tab = {dir_tab, mk_row(CMD_CLEAR, '1, '1, 1, '1, '1,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, '1, '1, 0, 8'd0, 32'd0,
                               1, ST_NOT_FOUND, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_INSERT, 64'd0, 64'd0, 0, 8'd128, 32'd0,
                               1, ST_OK, 32'd0, 8'd0)};
    dir_tab = {dir_tab, mk_row(CMD_LOOKUP, 64'd0, 64'd0, 0, 8'd0, 32'd0,
                               1, ST_OK, 32'd0, 8'd128)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].rsp);

    // episodes: clear, then mostly inserts and lookups around four base addresses, one ipv4 mapped
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      quiet = (n_rand >= 300 && n_rand < 650);
      if (!pressed && n_rand >= 1100) begin
        stall_rsp_req = 1;
        pressed = 1;
      end
      send_req(pool_req(CMD_CLEAR, 1), 0, '0);
      n_rand++;
      addr_pool[0] = {64'd0, V4_MAPPED_MARK, $urandom};
      for (int b = 1; b < 4; b++) addr_pool[b] = {$urandom, $urandom, $urandom, $urandom};
      replay.delete();
      big = ($urandom_range(0, 5) == 0);
      ep_len = big ? $urandom_range(80, 110) : $urandom_range(6, 30);
      repeat (ep_len) begin
        r = $urandom_range(0, 99);
        if (big && r < 70) rq = pool_req(CMD_INSERT, 1);
        else if (r < 40) rq = pool_req(CMD_INSERT, 0);
        else if (r < 82) rq = pool_req(CMD_LOOKUP, 0);
        else if (r < 90 && replay.size() > 0) begin
          rq = replay[$urandom_range(0, replay.size() - 1)];
          rq.row = $urandom;
        end
        else if (r < 94) rq = pool_req(CMD_LOOKUP, 1);
        else if (r < 98) rq = pool_req(CMD_UNUSED, 1);
        else rq = pool_req(CMD_CLEAR, 1);
        if (rq.cmd == CMD_INSERT) replay = {replay, rq};
        send_req(rq, 0, '0);
        n_rand++;
      end
    end
    quiet = 0;
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_N + 8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
